>>> sv/active_column_index_compaction_unit_defines.svh
// assertion macros for the active column index compaction unit
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef ACTIVE_COLUMN_INDEX_COMPACTION_UNIT_DEFINES_SVH
`define ACTIVE_COLUMN_INDEX_COMPACTION_UNIT_DEFINES_SVH

// same-cycle implication
`define ACICU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("acicu: same-cycle check failed");

// next-cycle implication
`define ACICU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("acicu: next-cycle check failed");

`endif

>>> sv/acicu_pkg.sv
// shared types and constants of the active column index compaction unit
// no dependencies
`timescale 1ns / 1ps

package acicu_pkg;

    localparam int MAX_RUNS_DEF = 1024;
    localparam int COL_W        = 31;

    localparam logic       KIND_LOAD  = 1'b0;
    localparam logic       KIND_REMAP = 1'b1;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_ZERO = 2'd3;

    typedef struct packed {
        logic             kind;
        logic             first_of_set;
        logic [COL_W-1:0] active_column;
        logic [COL_W-1:0] column_index;
    } t_item;

    typedef struct packed {
        logic [COL_W-1:0] mapped_index;
        logic [1:0]       status;
    } t_result;

    typedef struct packed {
        logic [COL_W-1:0] run_start;
        logic [COL_W-1:0] run_end;
        logic [COL_W-1:0] run_rank;
    } t_run;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SEARCH,
        S_FINAL
    } t_state;

endpackage

>>> sv/acicu_run_mem.sv
// run table memory: one write port, one registered read port
// depends on acicu_pkg
`timescale 1ns / 1ps

module acicu_run_mem #(
    parameter int DEPTH = acicu_pkg::MAX_RUNS_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output acicu_pkg::t_run o_rdata,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  acicu_pkg::t_run i_wdata
);

    acicu_pkg::t_run mem [DEPTH];
    acicu_pkg::t_run r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/acicu_ctrl.sv
// sequencer: load read-modify-write of the last run and binary search of remap items
// depends on acicu_pkg; drives the ports of acicu_run_mem
`timescale 1ns / 1ps

module acicu_ctrl #(
    parameter int MAX_RUNS = acicu_pkg::MAX_RUNS_DEF,
    localparam int IDX_W   = $clog2(MAX_RUNS),
    localparam int CNT_W   = $clog2(MAX_RUNS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  acicu_pkg::t_item   i_item,
    output logic               o_result_valid,
    output acicu_pkg::t_result o_result,
    output logic               o_mem_re,
    output logic [IDX_W-1:0]   o_mem_raddr,
    input  acicu_pkg::t_run    i_mem_rdata,
    output logic               o_mem_we,
    output logic [IDX_W-1:0]   o_mem_waddr,
    output acicu_pkg::t_run    o_mem_wdata
);

    localparam int CW = acicu_pkg::COL_W;

    acicu_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CW-1:0]      r_loaded, n_loaded;
    logic [IDX_W-1:0]   r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [CW-1:0]      r_id, n_id;
    logic               r_res_valid, n_res_valid;
    acicu_pkg::t_result r_res, n_res;

    logic               w_accept;
    logic [IDX_W-1:0]   w_last;
    logic               w_full;
    logic               w_go_right;
    logic [IDX_W-1:0]   w_step_lo, w_step_hi;
    logic               w_step_done;
    logic               w_hit;
    logic [CW-1:0]      w_offset;

    function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] lo,
                                                input logic [IDX_W-1:0] hi);
        logic [IDX_W:0] half;
        half = ({1'b0, hi} - {1'b0, lo} + {{IDX_W{1'b0}}, 1'b1}) >> 1;
        return lo + half[IDX_W-1:0];
    endfunction

    assign w_accept    = i_start && (r_state == acicu_pkg::S_IDLE);
    assign w_last      = IDX_W'(r_count - {{(CNT_W-1){1'b0}}, 1'b1});
    assign w_full      = (r_count == CNT_W'(MAX_RUNS));
    assign w_go_right  = (i_mem_rdata.run_start <= r_id);
    assign w_step_lo   = w_go_right ? r_mid : r_lo;
    assign w_step_hi   = w_go_right ? r_hi : (r_mid - {{(IDX_W-1){1'b0}}, 1'b1});
    assign w_step_done = !(w_step_lo < w_step_hi);
    assign w_hit       = (r_id >= i_mem_rdata.run_start) && (r_id <= i_mem_rdata.run_end);
    assign w_offset    = r_id - i_mem_rdata.run_start;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            acicu_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_item.kind == acicu_pkg::KIND_LOAD) begin
                        if (!i_item.first_of_set && (r_count != '0)) begin
                            n_state = acicu_pkg::S_LOAD;
                        end
                    end else if ((i_item.column_index != '0) && (r_count != '0)) begin
                        if (w_last == '0) begin
                            n_state = acicu_pkg::S_FINAL;
                        end else begin
                            n_state = acicu_pkg::S_SEARCH;
                        end
                    end
                end
            end
            acicu_pkg::S_LOAD: begin
                n_state = acicu_pkg::S_IDLE;
            end
            acicu_pkg::S_SEARCH: begin
                if (w_step_done) begin
                    n_state = acicu_pkg::S_FINAL;
                end
            end
            acicu_pkg::S_FINAL: begin
                n_state = acicu_pkg::S_IDLE;
            end
            default: begin
                n_state = acicu_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, memory requests and result
    always_comb begin
        n_count     = r_count;
        n_loaded    = r_loaded;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_id        = r_id;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_mid;
        o_mem_we    = 1'b0;
        o_mem_waddr = w_last;
        o_mem_wdata = i_mem_rdata;
        case (r_state)
            acicu_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_item.kind == acicu_pkg::KIND_LOAD) begin
                        n_id = i_item.active_column;
                        if (i_item.first_of_set || (r_count == '0)) begin
                            // table empty after the clear: the id opens run zero
                            o_mem_we              = 1'b1;
                            o_mem_waddr           = '0;
                            o_mem_wdata.run_start = i_item.active_column;
                            o_mem_wdata.run_end   = i_item.active_column;
                            o_mem_wdata.run_rank  = '0;
                            n_count               = {{(CNT_W-1){1'b0}}, 1'b1};
                            n_loaded              = {{(CW-1){1'b0}}, 1'b1};
                            n_res_valid           = 1'b1;
                            n_res.mapped_index    = '0;
                            n_res.status          = acicu_pkg::STAT_OK;
                        end else begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = w_last;
                        end
                    end else begin
                        n_id = i_item.column_index;
                        n_lo = '0;
                        n_hi = w_last;
                        if (i_item.column_index == '0) begin
                            n_res_valid        = 1'b1;
                            n_res.mapped_index = '0;
                            n_res.status       = acicu_pkg::STAT_ZERO;
                        end else if (r_count == '0) begin
                            n_res_valid        = 1'b1;
                            n_res.mapped_index = '0;
                            n_res.status       = acicu_pkg::STAT_MISS;
                        end else if (w_last == '0) begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = '0;
                        end else begin
                            n_mid       = mid_of('0, w_last);
                            o_mem_re    = 1'b1;
                            o_mem_raddr = n_mid;
                        end
                    end
                end
            end
            acicu_pkg::S_LOAD: begin
                n_res_valid        = 1'b1;
                n_res.mapped_index = '0;
                if (r_id <= i_mem_rdata.run_end) begin
                    n_res.status = acicu_pkg::STAT_MISS;
                end else if ({1'b0, r_id} == ({1'b0, i_mem_rdata.run_end} + 32'd1)) begin
                    // extend the last run
                    o_mem_we            = 1'b1;
                    o_mem_waddr         = w_last;
                    o_mem_wdata.run_end = r_id;
                    n_loaded            = r_loaded + {{(CW-1){1'b0}}, 1'b1};
                    n_res.status        = acicu_pkg::STAT_OK;
                end else if (w_full) begin
                    n_res.status = acicu_pkg::STAT_FULL;
                end else begin
                    o_mem_we              = 1'b1;
                    o_mem_waddr           = r_count[IDX_W-1:0];
                    o_mem_wdata.run_start = r_id;
                    o_mem_wdata.run_end   = r_id;
                    o_mem_wdata.run_rank  = r_loaded;
                    n_count               = r_count + {{(CNT_W-1){1'b0}}, 1'b1};
                    n_loaded              = r_loaded + {{(CW-1){1'b0}}, 1'b1};
                    n_res.status          = acicu_pkg::STAT_OK;
                end
            end
            acicu_pkg::S_SEARCH: begin
                n_lo     = w_step_lo;
                n_hi     = w_step_hi;
                o_mem_re = 1'b1;
                if (w_step_done) begin
                    o_mem_raddr = w_step_lo;
                end else begin
                    n_mid       = mid_of(w_step_lo, w_step_hi);
                    o_mem_raddr = n_mid;
                end
            end
            acicu_pkg::S_FINAL: begin
                n_res_valid = 1'b1;
                if (w_hit) begin
                    n_res.mapped_index = i_mem_rdata.run_rank + w_offset;
                    n_res.status       = acicu_pkg::STAT_OK;
                end else begin
                    n_res.mapped_index = '0;
                    n_res.status       = acicu_pkg::STAT_MISS;
                end
            end
            default: begin
                n_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= acicu_pkg::S_IDLE;
            r_count     <= '0;
            r_loaded    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_loaded    <= n_loaded;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_id  <= n_id;
        r_res <= n_res;
    end

    assign o_busy         = (r_state != acicu_pkg::S_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_result       = r_res;

endmodule

>>> sv/active_column_index_compaction_unit.sv
// load: a direct write into an empty table, else a read of the last run, then a write back
// remap: the result comes directly for column zero or an empty table, else after a binary
//   search with one run table read per search step; one item at a time
// result is registered and shown for one cycle; the next item may start in that cycle
// synchronous active-low reset empties the run table at once (count registers only)
`timescale 1ns / 1ps

`include "active_column_index_compaction_unit_defines.svh"

module active_column_index_compaction_unit #(
    parameter int MAX_RUNS = acicu_pkg::MAX_RUNS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  acicu_pkg::t_item   i_item,
    output logic               o_result_valid,
    output acicu_pkg::t_result o_result
);

    localparam int IDX_W = $clog2(MAX_RUNS);

    logic             w_mem_re;
    logic [IDX_W-1:0] w_mem_raddr;
    acicu_pkg::t_run  w_mem_rdata;
    logic             w_mem_we;
    logic [IDX_W-1:0] w_mem_waddr;
    acicu_pkg::t_run  w_mem_wdata;

    acicu_ctrl #(
        .MAX_RUNS (MAX_RUNS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .o_mem_re       (w_mem_re),
        .o_mem_raddr    (w_mem_raddr),
        .i_mem_rdata    (w_mem_rdata),
        .o_mem_we       (w_mem_we),
        .o_mem_waddr    (w_mem_waddr),
        .o_mem_wdata    (w_mem_wdata)
    );

    acicu_run_mem #(
        .DEPTH (MAX_RUNS)
    ) u_run_mem (
        .i_clk   (i_clk),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata)
    );

    `ACICU_ASSERT_NEXT(a_accept_progress, start && !busy, busy || o_result_valid)
    `ACICU_ASSERT_IMPL(a_no_read_on_write, w_mem_we, !w_mem_re)
    `ACICU_ASSERT_IMPL(a_miss_is_zero, o_result_valid && (o_result.status != acicu_pkg::STAT_OK), o_result.mapped_index == '0)
    `ACICU_ASSERT_IMPL(a_idle_no_read_without_start, !busy && !start, !w_mem_re && !w_mem_we)

endmodule
